>>> hdl/hwcm_pkg.sv
// Package for the projective coordinate generator.
// Holds transaction payload types, register indexes, status codes and coefficient bundle.
// No dependencies.
package hwcm_pkg;

    localparam int COORD_BITS    = 14;
    localparam int OUT_FRAC_BITS = 8;

    localparam int IN_W    = COORD_BITS;
    localparam int OUT_W   = COORD_BITS + OUT_FRAC_BITS;
    localparam int BOUND_W = COORD_BITS;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DEGEN  = 2'd1;
    localparam logic [1:0] ST_BOUNDS = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_OFFS   = 3'd2,
        REG_PERSP  = 3'd3,
        REG_H22    = 3'd4,
        REG_WIDTH  = 3'd5,
        REG_HEIGHT = 3'd6,
        REG_MODE   = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [IN_W-1:0] pano_x;
        logic [IN_W-1:0] pano_y;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [OUT_W-1:0] src_x;
        logic [OUT_W-1:0] src_y;
    } t_out;

    typedef struct packed {
        logic signed [31:0] h00;
        logic signed [31:0] h01;
        logic signed [31:0] h02;
        logic signed [31:0] h10;
        logic signed [31:0] h11;
        logic signed [31:0] h12;
        logic signed [31:0] h20;
        logic signed [31:0] h21;
        logic signed [31:0] h22;
    } t_coef;

    typedef struct packed {
        logic degen;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } t_side;

endpackage

>>> hdl/homography_warp_coordinate_map_top.sv
// Homography inverse-warp coordinate generator, top level.
// Pipeline: four front stages, one divider cell per quotient bit, one output register.
// Throughput one transaction per cycle; the whole pipeline holds while the output stalls.
// Reset clears all valid flags and loads identity coefficients, 2560x1440 bounds, direct mode.
// Uses hwcm_pkg, hwcm_front, hwcm_div_cell.
module homography_warp_coordinate_map_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  hwcm_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output hwcm_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_we,
    input  logic [hwcm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hwcm_pkg::CFG_W-1:0]        i_cfg_data
);
    import hwcm_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int OFB  = OUT_FRAC_BITS;
    localparam int MB   = CB + 35;
    localparam int QB   = CB + OFB;
    localparam int CMPW = ((CB > BOUND_W) ? CB : BOUND_W) + OFB + 1;
    localparam logic [OUT_W-1:0] FRAC_MASK = OUT_W'((64'd1 << OFB) - 64'd1);

    logic [63:0]        r_row0, r_row1, r_offs, r_persp;
    logic [31:0]        r_h22;
    logic [BOUND_W-1:0] r_width, r_height;
    logic               r_mode;
    t_coef              w_coef;
    logic               w_en;

    logic            w_v   [0:QB];
    logic [MB-1:0]   w_rx  [0:QB];
    logic [MB-1:0]   w_ry  [0:QB];
    logic [QB-1:0]   w_lx  [0:QB];
    logic [QB-1:0]   w_ly  [0:QB];
    logic [QB-1:0]   w_qx  [0:QB];
    logic [QB-1:0]   w_qy  [0:QB];
    logic [MB-1:0]   w_b   [0:QB];
    t_side           w_sd  [0:QB];

    logic [OUT_W:0]  w_ax, w_ay;
    t_out            n_out;

    function automatic logic [OUT_W:0] check_axis(
        input logic [QB-1:0]      q,
        input logic               ovf,
        input logic               neg,
        input logic [BOUND_W-1:0] bound,
        input logic               mode
    );
        logic [QB-1:0] t;
        logic          pass;
        logic [OUT_W-1:0] res;
        t = q >> OFB;
        if (mode) begin
            pass = !ovf && (!neg || (t == '0)) && (CMPW'(t) < CMPW'(bound));
            res  = OUT_W'(t << OFB);
        end else begin
            pass = !ovf && !neg && (CMPW'(q) < (CMPW'(bound) << OFB));
            res  = OUT_W'(q);
        end
        return {pass, res};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0   <= 64'h0001_0000_0000_0000;
            r_row1   <= 64'h0000_0000_0001_0000;
            r_offs   <= '0;
            r_persp  <= '0;
            r_h22    <= 32'h1000_0000;
            r_width  <= BOUND_W'(2560);
            r_height <= BOUND_W'(1440);
            r_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_ROW0:   r_row0   <= i_cfg_data;
                REG_ROW1:   r_row1   <= i_cfg_data;
                REG_OFFS:   r_offs   <= i_cfg_data;
                REG_PERSP:  r_persp  <= i_cfg_data;
                REG_H22:    r_h22    <= i_cfg_data[31:0];
                REG_WIDTH:  r_width  <= i_cfg_data[BOUND_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[BOUND_W-1:0];
                REG_MODE:   r_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_coef.h00 = signed'(r_row0[63:32]);
    assign w_coef.h01 = signed'(r_row0[31:0]);
    assign w_coef.h10 = signed'(r_row1[63:32]);
    assign w_coef.h11 = signed'(r_row1[31:0]);
    assign w_coef.h02 = signed'(r_offs[63:32]);
    assign w_coef.h12 = signed'(r_offs[31:0]);
    assign w_coef.h20 = signed'(r_persp[63:32]);
    assign w_coef.h21 = signed'(r_persp[31:0]);
    assign w_coef.h22 = signed'(r_h22);

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    assign w_qx[0] = '0;
    assign w_qy[0] = '0;

    hwcm_front #(.CB(CB), .OFB(OFB), .MB(MB), .QB(QB)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_x     (CB'(i_in_data.pano_x)),
        .i_y     (CB'(i_in_data.pano_y)),
        .i_coef  (w_coef),
        .o_valid (w_v[0]),
        .o_rem_x (w_rx[0]),
        .o_rem_y (w_ry[0]),
        .o_low_x (w_lx[0]),
        .o_low_y (w_ly[0]),
        .o_div   (w_b[0]),
        .o_side  (w_sd[0])
    );

    for (genvar k = 0; k < QB; k++) begin : g_cell
        hwcm_div_cell #(.MB(MB), .QB(QB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[k]),
            .i_rem_x (w_rx[k]),
            .i_rem_y (w_ry[k]),
            .i_low_x (w_lx[k]),
            .i_low_y (w_ly[k]),
            .i_q_x   (w_qx[k]),
            .i_q_y   (w_qy[k]),
            .i_div   (w_b[k]),
            .i_side  (w_sd[k]),
            .o_valid (w_v[k+1]),
            .o_rem_x (w_rx[k+1]),
            .o_rem_y (w_ry[k+1]),
            .o_low_x (w_lx[k+1]),
            .o_low_y (w_ly[k+1]),
            .o_q_x   (w_qx[k+1]),
            .o_q_y   (w_qy[k+1]),
            .o_div   (w_b[k+1]),
            .o_side  (w_sd[k+1])
        );
    end

    always_comb begin
        w_ax = check_axis(w_qx[QB], w_sd[QB].ovf_x, w_sd[QB].neg_x, r_width, r_mode);
        w_ay = check_axis(w_qy[QB], w_sd[QB].ovf_y, w_sd[QB].neg_y, r_height, r_mode);
        if (w_sd[QB].degen) begin
            n_out = '{status: ST_DEGEN, src_x: '0, src_y: '0};
        end else if (!w_ax[OUT_W] || !w_ay[OUT_W]) begin
            n_out = '{status: ST_BOUNDS, src_x: '0, src_y: '0};
        end else begin
            n_out = '{status: ST_OK, src_x: w_ax[OUT_W-1:0], src_y: w_ay[OUT_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= w_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out_data <= n_out;
        end
    end

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.status == ST_DEGEN
                         || o_out_data.status == ST_BOUNDS))
        else $error("unknown status code");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK)
            |-> (o_out_data.src_x == '0 && o_out_data.src_y == '0))
        else $error("invalid pixel with nonzero coordinates");

    a_undist_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_mode)
            |-> ((o_out_data.src_x & FRAC_MASK) == '0 && (o_out_data.src_y & FRAC_MASK) == '0))
        else $error("fraction bits set in map address");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && !o_in_ready || i_out_ready))
        else $error("pipeline advanced while output stalled");

endmodule

>>> hdl/hwcm_front.sv
// Front end: multiply-accumulate of the homography rows, magnitudes and divider setup.
// Four register stages; feeds the first divider cell. Uses hwcm_pkg.
module hwcm_front #(
    parameter int CB  = 14,
    parameter int OFB = 8,
    parameter int MB  = CB + 35,
    parameter int QB  = CB + OFB
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [CB-1:0]        i_x,
    input  logic [CB-1:0]        i_y,
    input  hwcm_pkg::t_coef      i_coef,
    output logic                 o_valid,
    output logic [MB-1:0]        o_rem_x,
    output logic [MB-1:0]        o_rem_y,
    output logic [QB-1:0]        o_low_x,
    output logic [QB-1:0]        o_low_y,
    output logic [MB-1:0]        o_div,
    output hwcm_pkg::t_side      o_side
);
    import hwcm_pkg::*;

    localparam int PW = 32 + CB + 1;
    localparam int NB = MB;
    localparam int DS = 12 + OFB;
    localparam int WD = MB + DS;

    logic signed [CB:0]    w_xs, w_ys;
    logic signed [PW-1:0]  w_p00, w_p01, w_p10, w_p11, w_p20, w_p21;
    logic signed [PW-1:0]  r_p00, r_p01, r_p10, r_p11, r_p20, r_p21;
    logic signed [NB-1:0]  r_nx, r_ny, r_d;
    logic [MB-1:0]         r_ax, r_ay, r_b;
    logic                  r_negx, r_negy, r_degen;
    logic [WD-1:0]         w_dx, w_dy, w_r0x, w_r0y;
    logic [3:0]            r_v;

    assign w_xs = {1'b0, i_x};
    assign w_ys = {1'b0, i_y};
    assign w_p00 = i_coef.h00 * w_xs;
    assign w_p01 = i_coef.h01 * w_ys;
    assign w_p10 = i_coef.h10 * w_xs;
    assign w_p11 = i_coef.h11 * w_ys;
    assign w_p20 = i_coef.h20 * w_xs;
    assign w_p21 = i_coef.h21 * w_ys;

    assign w_dx  = {r_ax, {DS{1'b0}}};
    assign w_dy  = {r_ay, {DS{1'b0}}};
    assign w_r0x = w_dx >> QB;
    assign w_r0y = w_dy >> QB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= w_p00;
            r_p01 <= w_p01;
            r_p10 <= w_p10;
            r_p11 <= w_p11;
            r_p20 <= w_p20;
            r_p21 <= w_p21;

            r_nx <= NB'(r_p00) + NB'(r_p01) + NB'(i_coef.h02);
            r_ny <= NB'(r_p10) + NB'(r_p11) + NB'(i_coef.h12);
            r_d  <= NB'(r_p20) + NB'(r_p21) + NB'(i_coef.h22);

            r_ax    <= r_nx[NB-1] ? MB'(-r_nx) : MB'(r_nx);
            r_ay    <= r_ny[NB-1] ? MB'(-r_ny) : MB'(r_ny);
            r_b     <= r_d[NB-1]  ? MB'(-r_d)  : MB'(r_d);
            r_negx  <= (r_nx != '0) && (r_nx[NB-1] != r_d[NB-1]);
            r_negy  <= (r_ny != '0) && (r_ny[NB-1] != r_d[NB-1]);
            r_degen <= (r_d == '0);

            o_rem_x      <= MB'(w_r0x);
            o_rem_y      <= MB'(w_r0y);
            o_low_x      <= w_dx[QB-1:0];
            o_low_y      <= w_dy[QB-1:0];
            o_div        <= r_b;
            o_side.degen <= r_degen;
            o_side.neg_x <= r_negx;
            o_side.neg_y <= r_negy;
            o_side.ovf_x <= (w_r0x >= WD'(r_b));
            o_side.ovf_y <= (w_r0y >= WD'(r_b));
        end
    end

    assign o_valid = r_v[3];

endmodule

>>> hdl/hwcm_div_cell.sv
// One restoring-division cell: retires one quotient bit per axis and hands on.
// Chained to form the divider. Uses hwcm_pkg.
module hwcm_div_cell #(
    parameter int MB = 49,
    parameter int QB = 22
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [MB-1:0]   i_rem_x,
    input  logic [MB-1:0]   i_rem_y,
    input  logic [QB-1:0]   i_low_x,
    input  logic [QB-1:0]   i_low_y,
    input  logic [QB-1:0]   i_q_x,
    input  logic [QB-1:0]   i_q_y,
    input  logic [MB-1:0]   i_div,
    input  hwcm_pkg::t_side i_side,
    output logic            o_valid,
    output logic [MB-1:0]   o_rem_x,
    output logic [MB-1:0]   o_rem_y,
    output logic [QB-1:0]   o_low_x,
    output logic [QB-1:0]   o_low_y,
    output logic [QB-1:0]   o_q_x,
    output logic [QB-1:0]   o_q_y,
    output logic [MB-1:0]   o_div,
    output hwcm_pkg::t_side o_side
);
    import hwcm_pkg::*;

    logic [MB:0] w_tx, w_ty, w_bd;
    logic        w_gex, w_gey;

    assign w_tx  = {i_rem_x, i_low_x[QB-1]};
    assign w_ty  = {i_rem_y, i_low_y[QB-1]};
    assign w_bd  = {1'b0, i_div};
    assign w_gex = (w_tx >= w_bd);
    assign w_gey = (w_ty >= w_bd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem_x <= w_gex ? MB'(w_tx - w_bd) : MB'(w_tx);
            o_rem_y <= w_gey ? MB'(w_ty - w_bd) : MB'(w_ty);
            o_low_x <= {i_low_x[QB-2:0], 1'b0};
            o_low_y <= {i_low_y[QB-2:0], 1'b0};
            o_q_x   <= {i_q_x[QB-2:0], w_gex};
            o_q_y   <= {i_q_y[QB-2:0], w_gey};
            o_div   <= i_div;
            o_side  <= i_side;
        end
    end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for homography_warp_coordinate_map_top.
// A predictor of the projective map and bounds check runs on every accepted transaction.
// Depends on hwcm_pkg and the RTL top level.
module testbench;
    import hwcm_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in                i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out               o_out_data;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    logic [63:0] cur_row0, cur_row1, cur_offs, cur_persp;
    logic [31:0] cur_h22;
    logic [13:0] cur_width, cur_height;
    logic        cur_undist;

    t_in  pending_px[$];
    t_out expected_map[$];
    bit   idle_on;
    int   mismatches;
    int   n_sent;
    int   n_checked;
    int   n_valid, n_degen, n_bounds;

    homography_warp_coordinate_map_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic bit src_axis(longint n, longint dd, logic [13:0] bound,
                                    output longint unsigned res);
        longint unsigned a, b, q, r, t;
        bit neg;
        a = (n < 0) ? -n : n;
        b = (dd < 0) ? -dd : dd;
        q = a / b;
        r = a % b;
        res = 0;
        if (q > 65536) q = 65536;
        for (int i = 0; i < 20; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
                r = r - b;
                q = q | 1;
            end
        end
        neg = (n != 0) && ((n < 0) != (dd < 0));
        if (cur_undist) begin
            t = q >> 8;
            if (neg && t != 0) return 1'b0;
            if (t >= bound) return 1'b0;
            res = t << 8;
            return 1'b1;
        end
        if (neg) return 1'b0;
        if (q >= (longint'(bound) << 8)) return 1'b0;
        res = q;
        return 1'b1;
    endfunction

    function automatic t_out warp_predict(t_in px);
        longint x, y, nx, ny, dd;
        longint unsigned sx, sy;
        t_out r;
        x = px.pano_x;
        y = px.pano_y;
        nx = sx32(cur_row0[63:32]) * x + sx32(cur_row0[31:0]) * y + sx32(cur_offs[63:32]);
        ny = sx32(cur_row1[63:32]) * x + sx32(cur_row1[31:0]) * y + sx32(cur_offs[31:0]);
        dd = sx32(cur_persp[63:32]) * x + sx32(cur_persp[31:0]) * y + sx32(cur_h22);
        r = '0;
        if (dd == 0) begin
            r.status = ST_DEGEN;
        end else if (!src_axis(nx, dd, cur_width, sx) || !src_axis(ny, dd, cur_height, sy)) begin
            r.status = ST_BOUNDS;
        end else begin
            r.status = ST_OK;
            r.src_x  = sx[OUT_W-1:0];
            r.src_y  = sy[OUT_W-1:0];
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_map = {expected_map, warp_predict(i_in_data)};
                n_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_px.size() > 0 && !(idle_on && $urandom_range(0, 99) < 17)) begin
                    i_in_data  <= pending_px.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_map.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %p", o_out_data);
                end else begin
                    exp_r = expected_map.pop_front();
                    n_checked++;
                    case (exp_r.status)
                        ST_OK:    n_valid++;
                        ST_DEGEN: n_degen++;
                        default:  n_bounds++;
                    endcase
                    if (o_out_data.status !== exp_r.status || o_out_data.src_x !== exp_r.src_x
                        || o_out_data.src_y !== exp_r.src_y) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected st=%0d x=%h y=%h, got st=%0d x=%h y=%h",
                                     exp_r.status, exp_r.src_x, exp_r.src_y, o_out_data.status,
                                     o_out_data.src_x, o_out_data.src_y);
                    end
                end
            end
            i_out_ready <= idle_on ? ($urandom_range(0, 99) >= 17) : 1'b1;
        end
    end

    task automatic write_reg(t_cfg_reg idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_ROW0:   cur_row0   = val;
            REG_ROW1:   cur_row1   = val;
            REG_OFFS:   cur_offs   = val;
            REG_PERSP:  cur_persp  = val;
            REG_H22:    cur_h22    = val[31:0];
            REG_WIDTH:  cur_width  = val[13:0];
            REG_HEIGHT: cur_height = val[13:0];
            default:    cur_undist = val[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_px(int x, int y);
        t_in p;
        p.pano_x = 14'(x);
        p.pano_y = 14'(y);
        pending_px = {pending_px, p};
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_px.size() != 0 || i_in_valid || expected_map.size() != 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic random_config(bit wild);
        int h00, h01, h10, h11, h02, h12, h20, h21, h22;
        if (wild) begin
            write_reg(REG_ROW0, {$urandom, $urandom});
            write_reg(REG_ROW1, {$urandom, $urandom});
            write_reg(REG_OFFS, {$urandom, $urandom});
            write_reg(REG_PERSP, {$urandom, $urandom});
            write_reg(REG_H22, {32'h0, $urandom});
        end else begin
            h00 = $urandom_range(8192, 131072);
            h01 = $urandom_range(0, 16384) - 8192;
            h10 = $urandom_range(0, 16384) - 8192;
            h11 = $urandom_range(8192, 131072);
            h02 = $urandom_range(0, 1000 * 65536) - 200 * 65536;
            h12 = $urandom_range(0, 600 * 65536) - 100 * 65536;
            h20 = $urandom_range(0, 4096) - 2048;
            h21 = $urandom_range(0, 4096) - 2048;
            h22 = 268435456 + $urandom_range(0, 1 << 26) - (1 << 25);
            write_reg(REG_ROW0, {h00, h01});
            write_reg(REG_ROW1, {h10, h11});
            write_reg(REG_OFFS, {h02, h12});
            write_reg(REG_PERSP, {h20, h21});
            write_reg(REG_H22, {32'h0, h22});
        end
        write_reg(REG_WIDTH, ($urandom_range(0, 3) == 0) ? 64'd16383 : $urandom_range(1, 3000));
        write_reg(REG_HEIGHT, ($urandom_range(0, 3) == 0) ? 64'd16383 : $urandom_range(1, 2000));
        write_reg(REG_MODE, $urandom_range(0, 1));
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_ROW0;
        i_cfg_data = '0;
        idle_on    = 1'b1;
        mismatches = 0;
        n_sent = 0; n_checked = 0; n_valid = 0; n_degen = 0; n_bounds = 0;
        cur_row0 = 64'h0001_0000_0000_0000;
        cur_row1 = 64'h0000_0000_0001_0000;
        cur_offs = '0;
        cur_persp = '0;
        cur_h22 = 32'h1000_0000;
        cur_width = 14'd2560;
        cur_height = 14'd1440;
        cur_undist = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity map at reset values
        add_px(0, 0); add_px(16383, 16383); add_px(2559, 1439); add_px(2560, 0);
        add_px(0, 1440); add_px(100, 200); add_px(10922, 5461); add_px(5461, 10922);
        drain();

        // zero denominator, then a tiny one that saturates the divider
        write_reg(REG_H22, 64'h0);
        add_px(0, 0); add_px(5, 7);
        drain();
        write_reg(REG_PERSP, {32'd1, 32'd0});
        add_px(0, 0); add_px(1, 0); add_px(16383, 0);
        drain();

        // slightly negative coordinate, both modes; then zero bounds
        write_reg(REG_PERSP, 64'h0);
        write_reg(REG_H22, 64'h1000_0000);
        write_reg(REG_OFFS, 64'hFFFF8000_FFFF8000);
        write_reg(REG_MODE, 64'd1);
        add_px(0, 0); add_px(3, 2); add_px(2559, 1439);
        drain();
        write_reg(REG_MODE, 64'd0);
        add_px(0, 0); add_px(3, 2);
        drain();
        write_reg(REG_WIDTH, 64'd0);
        write_reg(REG_HEIGHT, 64'd0);
        add_px(0, 0); add_px(1, 1);
        drain();

        // coefficient extremes
        write_reg(REG_ROW0, 64'h7FFFFFFF_80000000);
        write_reg(REG_ROW1, 64'h80000000_7FFFFFFF);
        write_reg(REG_OFFS, 64'hFFFFFFFF_FFFFFFFF);
        write_reg(REG_PERSP, 64'h80000000_7FFFFFFF);
        write_reg(REG_H22, 64'h8000_0000);
        write_reg(REG_WIDTH, 64'd16383);
        write_reg(REG_HEIGHT, 64'd16383);
        add_px(0, 0); add_px(16383, 0); add_px(0, 16383); add_px(16383, 16383);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            random_config(ph == 4);
            idle_on = (ph != 2);
            for (int k = 0; k < 300; k++) begin
                if ($urandom_range(0, 3) != 0)
                    add_px($urandom_range(0, cur_width), $urandom_range(0, cur_height));
                else
                    add_px($urandom_range(0, 16383), $urandom_range(0, 16383));
            end
            drain();
        end

        $display("covered %0d transactions: %0d valid, %0d degenerate, %0d out of bounds",
                 n_checked, n_valid, n_degen, n_bounds);
        $display("direct and undistort modes, identity, extreme and random coefficient sets");
        if (mismatches == 0 && expected_map.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> homography_warp_coordinate_map_top.f
hdl/hwcm_pkg.sv
hdl/hwcm_front.sv
hdl/hwcm_div_cell.sv
hdl/homography_warp_coordinate_map_top.sv
tb/testbench.sv
